// ===== rtl/rlpd_pkg.sv =====
`timescale 1ns / 1ps
package rlpd_pkg;

  localparam int NUM_COEF = 8;
  localparam int APB_AW = 6;
  localparam logic signed [32:0] TOL_LSB = 33'sd17;
  localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
  localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

  typedef logic [NUM_COEF-1:0][47:0] coef_bank_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_WAIT,
    ST_CHECK
  } state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SQX,
    CMD_SQY,
    CMD_SQRT,
    CMD_R3,
    CMD_TERM,
    CMD_UPDATE
  } cmd_t;

  typedef struct packed {
    cmd_t       op;
    logic [2:0] idx;
    logic       go;
    logic       first;
    logic       last;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic finished;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if (v > SAT_HI) begin
      res = {1'b0, {31{1'b1}}};
    end else if (v < SAT_LO) begin
      res = {1'b1, 31'b0};
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // rounding bias for terms c0, c1*r, c2*r2, c3*r3 (shifts 16, 40, 64, 40)
  function automatic logic [63:0] term_bias(input logic [1:0] k);
    logic [63:0] b;
    unique case (k)
      2'd0: b = 64'd1 << 15;
      2'd1: b = 64'd1 << 39;
      2'd2: b = 64'd1 << 63;
      default: b = 64'd1 << 39;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/rlpd_req_if.sv =====
`timescale 1ns / 1ps
interface rlpd_req_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;

  modport src (output valid, output opcode, output in_x, output in_y, input ready);
  modport snk (input valid, input opcode, input in_x, input in_y, output ready);
endinterface

// ===== rtl/rlpd_rsp_if.sv =====
`timescale 1ns / 1ps
interface rlpd_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic               converged;

  modport src (output valid, output out_x, output out_y, output converged, input ready);
  modport snk (input valid, input out_x, input out_y, input converged, output ready);
endinterface

// ===== rtl/rlpd_mul.sv =====
`timescale 1ns / 1ps
module rlpd_mul (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  input  logic [63:0]  bias,
  output logic [127:0] prod,
  output logic         done
);

  logic [63:0]  a_r;
  logic [63:0]  b_r;
  logic [2:0]   cnt;
  logic         busy;
  logic [63:0]  pp;
  logic [1:0]   pp_sel;
  logic         pp_v;
  logic [31:0]  a_h;
  logic [31:0]  b_h;
  logic [127:0] pp_sh;

  assign a_h = cnt[0] ? a_r[63:32] : a_r[31:0];
  assign b_h = cnt[1] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    unique case (pp_sel)
      2'd0: pp_sh = {64'b0, pp};
      2'd3: pp_sh = {pp, 64'b0};
      default: pp_sh = {32'b0, pp, 32'b0};
    endcase
  end

  // one 32x32 partial product per cycle, accumulated in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pp_v <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        prod <= {64'b0, bias};
        cnt  <= 3'd0;
        busy <= 1'b1;
        pp_v <= 1'b0;
      end else if (busy) begin
        if (cnt != 3'd4) begin
          pp     <= 64'(a_h) * 64'(b_h);
          pp_sel <= cnt[1:0];
          pp_v   <= 1'b1;
          cnt    <= cnt + 3'd1;
        end else begin
          pp_v <= 1'b0;
          busy <= 1'b0;
          done <= 1'b1;
        end
        if (pp_v) begin
          prod <= prod + pp_sh;
        end
      end
    end
  end

endmodule

// ===== rtl/rlpd_sqrt.sv =====
`timescale 1ns / 1ps
module rlpd_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] n,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] n_r;
  logic [34:0] rem;
  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic [4:0]  cnt;
  logic        busy;

  assign rem_sh = {rem[32:0], n_r[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  // restoring square root, one result bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_r  <= n;
        rem  <= 35'd0;
        root <= 32'd0;
        cnt  <= 5'd0;
        busy <= 1'b1;
      end else if (busy) begin
        n_r <= {n_r[61:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/rlpd_dp.sv =====
`timescale 1ns / 1ps
module rlpd_dp import rlpd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  coef_bank_t         coef,
  input  logic               opcode,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic               converged
);

  logic               op_r;
  logic signed [31:0] ix;
  logic signed [31:0] iy;
  logic signed [31:0] tx;
  logic signed [31:0] ty;
  logic [63:0]        r2;
  logic [31:0]        r;
  logic [47:0]        r3;
  logic signed [63:0] acc_x;
  logic signed [63:0] acc_y;
  logic [31:0]        ax;
  logic [31:0]        ay;
  logic [1:0]         k;
  logic               axis;
  logic [47:0]        craw;
  logic [47:0]        cmag;
  logic               cneg;
  logic [63:0]        vsel;
  logic [63:0]        mul_a;
  logic [63:0]        mul_b;
  logic [63:0]        mul_bias;
  logic [63:0]        term;
  logic               mul_start;
  logic               mul_done;
  logic [127:0]       prod;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [31:0]        sqrt_root;
  logic signed [63:0] acc_sel;
  logic signed [63:0] acc_new;
  logic signed [65:0] sum_x;
  logic signed [65:0] sum_y;
  logic signed [31:0] nx;
  logic signed [31:0] ny;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic               hit;
  logic               fin;

  assign ax   = tx[31] ? (~$unsigned(tx) + 32'd1) : $unsigned(tx);
  assign ay   = ty[31] ? (~$unsigned(ty) + 32'd1) : $unsigned(ty);
  assign k    = cmd.idx[1:0];
  assign axis = cmd.idx[2];
  assign craw = coef[cmd.idx];
  assign cneg = craw[47];
  // most negative raw value maps to 2^47, as wanted
  assign cmag = cneg ? (~craw + 48'd1) : craw;

  always_comb begin
    unique case (k)
      2'd0: vsel = 64'd1;
      2'd1: vsel = {32'b0, r};
      2'd2: vsel = r2;
      default: vsel = {16'b0, r3};
    endcase
  end

  always_comb begin
    unique case (cmd.op)
      CMD_SQX: begin
        mul_a    = {32'b0, ax};
        mul_b    = {32'b0, ax};
        mul_bias = 64'd0;
      end
      CMD_SQY: begin
        mul_a    = {32'b0, ay};
        mul_b    = {32'b0, ay};
        mul_bias = 64'd0;
      end
      CMD_R3: begin
        mul_a    = r2;
        mul_b    = {32'b0, r};
        mul_bias = 64'd1 << 47;
      end
      default: begin
        mul_a    = {16'b0, cmag};
        mul_b    = vsel;
        mul_bias = term_bias(k);
      end
    endcase
  end

  assign mul_start  = cmd.go && (cmd.op == CMD_SQX || cmd.op == CMD_SQY ||
                                 cmd.op == CMD_R3 || cmd.op == CMD_TERM);
  assign sqrt_start = cmd.go && (cmd.op == CMD_SQRT);

  rlpd_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .bias (mul_bias),
    .prod (prod),
    .done (mul_done)
  );

  rlpd_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sqrt_start),
    .n    (r2),
    .root (sqrt_root),
    .done (sqrt_done)
  );

  always_comb begin
    unique case (k)
      2'd0: term = prod[79:16];
      2'd1: term = prod[103:40];
      2'd2: term = prod[127:64];
      default: term = prod[103:40];
    endcase
  end

  assign acc_sel = axis ? acc_y : acc_x;
  assign acc_new = ((k == 2'd0) ? 64'sd0 : acc_sel)
                 + (cneg ? -$signed(term) : $signed(term));

  assign sum_x = op_r ? (66'(ix) - 66'(acc_x)) : (66'(ix) + 66'(acc_x));
  assign sum_y = op_r ? (66'(iy) - 66'(acc_y)) : (66'(iy) + 66'(acc_y));
  assign nx    = sat32(sum_x);
  assign ny    = sat32(sum_y);
  assign dx    = 33'(nx) - 33'(tx);
  assign dy    = 33'(ny) - 33'(ty);
  assign hit   = !cmd.first && (dx > -TOL_LSB) && (dx < TOL_LSB)
                 && (dy > -TOL_LSB) && (dy < TOL_LSB);
  assign fin   = !op_r || hit || cmd.last;

  assign stat.done     = mul_done | sqrt_done;
  assign stat.finished = fin;

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      unique case (cmd.op)
        CMD_LOAD: begin
          op_r <= opcode;
          ix   <= in_x;
          iy   <= in_y;
          tx   <= in_x;
          ty   <= in_y;
        end
        CMD_UPDATE: begin
          tx <= nx;
          ty <= ny;
          if (fin) begin
            out_x     <= (!op_r || hit) ? nx : 32'sd0;
            out_y     <= (!op_r || hit) ? ny : 32'sd0;
            converged <= !op_r || hit;
          end
        end
        default: begin
        end
      endcase
    end
    if (mul_done) begin
      unique case (cmd.op)
        CMD_SQX: r2 <= prod[63:0];
        CMD_SQY: r2 <= r2 + prod[63:0];
        CMD_R3:  r3 <= prod[95:48];
        CMD_TERM: begin
          if (axis) begin
            acc_y <= acc_new;
          end else begin
            acc_x <= acc_new;
          end
        end
        default: begin
        end
      endcase
    end
    if (sqrt_done) begin
      r <= sqrt_root;
    end
  end

endmodule

// ===== rtl/rlpd_ctrl.sv =====
`timescale 1ns / 1ps
module rlpd_ctrl import rlpd_pkg::*; #(
  parameter int MAX_PASSES = 50
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam int PW = $clog2(MAX_PASSES + 1);

  state_t     state;
  state_t     state_next;
  cmd_t       cur;
  cmd_t       cur_next;
  logic [2:0] idx;
  logic [2:0] idx_next;
  logic [PW-1:0] pass;
  logic [PW-1:0] pass_next;
  logic       out_pend;
  logic       out_pend_next;
  logic       finish_go;

  always_comb begin
    cmd.op    = cur;
    cmd.idx   = idx;
    cmd.first = (pass == '0);
    cmd.last  = (pass == PW'(MAX_PASSES - 1));
    cmd.go    = 1'b0;
    in_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.op   = CMD_LOAD;
        cmd.go   = in_valid;
        in_ready = 1'b1;
      end
      ST_ISSUE: cmd.go = 1'b1;
      ST_WAIT:  cmd.go = 1'b0;
      ST_CHECK: begin
        cmd.op = CMD_UPDATE;
        // hold the result back while the previous one is still untaken
        cmd.go = !(stat.finished && out_pend && !out_ready);
      end
      default: cmd.go = 1'b0;
    endcase
  end

  assign out_valid = out_pend;
  assign finish_go = (state == ST_CHECK) && cmd.go && stat.finished;

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    idx_next      = idx;
    pass_next     = pass;
    out_pend_next = finish_go || (out_pend && !out_ready);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ISSUE;
          cur_next   = CMD_SQX;
          idx_next   = 3'd0;
          pass_next  = '0;
        end
      end
      ST_ISSUE: state_next = ST_WAIT;
      ST_WAIT: begin
        if (stat.done) begin
          state_next = ST_ISSUE;
          priority case (cur)
            CMD_SQX:  cur_next = CMD_SQY;
            CMD_SQY:  cur_next = CMD_SQRT;
            CMD_SQRT: cur_next = CMD_R3;
            CMD_R3: begin
              cur_next = CMD_TERM;
              idx_next = 3'd0;
            end
            default: begin
              if (idx == 3'd7) begin
                state_next = ST_CHECK;
              end else begin
                idx_next = idx + 3'd1;
              end
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (cmd.go) begin
          if (stat.finished) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ISSUE;
            cur_next   = CMD_SQX;
            idx_next   = 3'd0;
            pass_next  = pass + PW'(1);
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      cur      <= CMD_SQX;
      idx      <= 3'd0;
      pass     <= '0;
      out_pend <= 1'b0;
    end else begin
      state    <= state_next;
      cur      <= cur_next;
      idx      <= idx_next;
      pass     <= pass_next;
      out_pend <= out_pend_next;
    end
  end

endmodule

// ===== rtl/radial_poly_lens_distortion_map_top.sv =====
`timescale 1ns / 1ps
// each pass runs eleven 4-partial-product multiplies on the shared 32x32 multiplier,
// a bit-serial square root and an update step; opcode 0 takes a single pass, opcode 1
// takes up to MAX_PASSES passes. one item is in flight at a time; a finished result
// waits in the output register while the next item is taken.
// reset (rst, synchronous): control idle, no result pending, coefficients zero.
module radial_poly_lens_distortion_map_top import rlpd_pkg::*; #(
  parameter int MAX_PASSES = 50
) (
  input  logic              clk,
  input  logic              rst,
  rlpd_req_if.snk           req,
  rlpd_rsp_if.src           rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);

  coef_bank_t coef;
  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign prdata  = {16'b0, coef[reg_idx]};

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (psel && penable && pwrite) begin
      coef[reg_idx] <= pwdata[47:0];
    end
  end

  rlpd_ctrl #(
    .MAX_PASSES(MAX_PASSES)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .out_valid(rsp.valid),
    .out_ready(rsp.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  rlpd_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .coef     (coef),
    .opcode   (req.opcode),
    .in_x     (req.in_x),
    .in_y     (req.in_y),
    .out_x    (rsp.out_x),
    .out_y    (rsp.out_y),
    .converged(rsp.converged)
  );

endmodule

// ===== tb/sv/tb_radial_poly_lens_distortion_map_top.sv =====
`timescale 1ns / 1ps
module tb_radial_poly_lens_distortion_map_top;
  import rlpd_pkg::*;

  localparam logic OP_REMOVE = 1'b0;
  localparam logic OP_ADD    = 1'b1;
  localparam int REG_COEF_X0 = 0;
  localparam int REG_COEF_Y0 = 4;
  localparam int PASS_LIMIT  = 50;
  localparam int TOL         = 17;
  localparam longint CYCLE_LIMIT = 12000000;

  typedef struct {
    logic               op;
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               conv;
  } mapped_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [63:0] pwdata, prdata;
  logic pready;

  rlpd_req_if req ();
  rlpd_rsp_if rsp ();

  radial_poly_lens_distortion_map_top dut (
    .clk(clk), .rst(rst), .req(req.snk), .rsp(rsp.src),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  logic [47:0] lens_coef [8];
  point_t  pending_points [$];
  mapped_t mapped_expect [$];
  point_t  cur_point;
  int      errors = 0;
  int      n_remove = 0, n_add = 0, n_diverged = 0, n_checked = 0;
  int      burst_left = 0, gap_left = 0;
  int      stall_mode = 0;
  longint  cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // rounded unsigned product a*b / 2^s
  function automatic logic [63:0] scale_round(logic [63:0] a, logic [63:0] b, int s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (s - 1));
    return 64'(p >> s);
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [63:0] coef_term(logic [47:0] raw, logic [63:0] v, int s);
    logic [47:0] mag;
    logic [63:0] q;
    mag = raw[47] ? -raw : raw;
    q = scale_round({16'd0, mag}, v, s);
    return raw[47] ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic radial_offsets(input logic signed [31:0] x, input logic signed [31:0] y,
                                output logic signed [63:0] ox,
                                output logic signed [63:0] oy);
    logic [63:0] ax, ay, r2, r, r3;
    ax = x < 0 ? -{{32{x[31]}}, x} : {32'd0, x};
    ay = y < 0 ? -{{32{y[31]}}, y} : {32'd0, y};
    r2 = ax * ax + ay * ay;
    r  = floor_sqrt(r2);
    r3 = scale_round(r2, r, 48);
    ox = coef_term(lens_coef[0], 64'd1, 16) + coef_term(lens_coef[1], r, 40)
       + coef_term(lens_coef[2], r2, 64) + coef_term(lens_coef[3], r3, 40);
    oy = coef_term(lens_coef[4], 64'd1, 16) + coef_term(lens_coef[5], r, 40)
       + coef_term(lens_coef[6], r2, 64) + coef_term(lens_coef[7], r3, 40);
  endtask

  task automatic map_point(input point_t p, output mapped_t m);
    logic signed [63:0] ox, oy;
    logic signed [31:0] tx, ty, px, py;
    logic signed [32:0] dx, dy;
    m.x = 0;
    m.y = 0;
    m.conv = 1'b0;
    if (p.op == OP_REMOVE) begin
      radial_offsets(p.x, p.y, ox, oy);
      m.x = clamp32($signed({{34{p.x[31]}}, p.x}) + $signed({{2{ox[63]}}, ox}));
      m.y = clamp32($signed({{34{p.y[31]}}, p.y}) + $signed({{2{oy[63]}}, oy}));
      m.conv = 1'b1;
    end else begin
      tx = p.x;
      ty = p.y;
      px = 0;
      py = 0;
      for (int pass = 0; pass < PASS_LIMIT; pass++) begin
        radial_offsets(tx, ty, ox, oy);
        tx = clamp32($signed({{34{p.x[31]}}, p.x}) - $signed({{2{ox[63]}}, ox}));
        ty = clamp32($signed({{34{p.y[31]}}, p.y}) - $signed({{2{oy[63]}}, oy}));
        dx = $signed({tx[31], tx}) - $signed({px[31], px});
        dy = $signed({ty[31], ty}) - $signed({py[31], py});
        if (pass > 0 && dx > -TOL && dx < TOL && dy > -TOL && dy < TOL) begin
          m.x = tx;
          m.y = ty;
          m.conv = 1'b1;
          break;
        end
        px = tx;
        py = ty;
      end
    end
  endtask

  task automatic write_coef(input int idx, input logic [47:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(idx * 8);
    pwdata  <= {{16{val[47]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    lens_coef[idx] = val;
  endtask

  // signed random in roughly +-2^bits
  function automatic logic [63:0] rand_mag(int bits);
    logic signed [63:0] v;
    v = {$urandom, $urandom};
    return v >>> (63 - bits);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return 32'(rand_mag(27));
  endfunction

  task automatic push_point(input logic op, input logic signed [31:0] x,
                            input logic signed [31:0] y);
    point_t p;
    p.op = op;
    p.x = x;
    p.y = y;
    pending_points = {pending_points, p};
  endtask

  task automatic push_random(input int n, input int add_pct);
    for (int i = 0; i < n; i++)
      push_point($urandom_range(0, 99) < add_pct ? OP_ADD : OP_REMOVE,
                 rand_coord(), rand_coord());
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || req.valid || mapped_expect.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_small_set();
    write_coef(REG_COEF_X0, 48'(rand_mag(38)));
    write_coef(REG_COEF_X0 + 1, 48'(rand_mag(34)));
    write_coef(REG_COEF_X0 + 2, 48'(rand_mag(30)));
    write_coef(REG_COEF_X0 + 3, 48'(rand_mag(26)));
    write_coef(REG_COEF_Y0, 48'(rand_mag(38)));
    write_coef(REG_COEF_Y0 + 1, 48'(rand_mag(34)));
    write_coef(REG_COEF_Y0 + 2, 48'(rand_mag(30)));
    write_coef(REG_COEF_Y0 + 3, 48'(rand_mag(26)));
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    mapped_t m;
    point_t nxt;
    if (rst) begin
      req.valid <= 1'b0;
    end else begin
      if (req.valid && req.ready) begin
        map_point(cur_point, m);
        mapped_expect = {mapped_expect, m};
        if (cur_point.op == OP_ADD) n_add++; else n_remove++;
        if (!m.conv) n_diverged++;
      end
      if (!req.valid || req.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req.valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          nxt = pending_points.pop_front();
          cur_point = nxt;
          req.valid  <= 1'b1;
          req.opcode <= nxt.op;
          req.in_x   <= nxt.x;
          req.in_y   <= nxt.y;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 300);
          end else begin
            burst_left--;
          end
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall behavior switches between four modes, chosen at random
  always @(posedge clk) begin
    mapped_t e;
    cycles++;
    if (cycles % 500 == 0) stall_mode = $urandom_range(0, 3);
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: begin
          rsp.ready <= 1'b1;
        end
        1: begin
          rsp.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          rsp.ready <= $urandom_range(0, 15) == 0;
        end
        default: begin
          rsp.ready <= (cycles % 200) > 150;
        end
      endcase
      if (rsp.valid && rsp.ready) begin
        if (mapped_expect.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer x=%0d y=%0d conv=%0b", $time,
                   rsp.out_x, rsp.out_y, rsp.converged);
        end else begin
          e = mapped_expect.pop_front();
          n_checked++;
          if (rsp.out_x !== e.x) begin
            errors++;
            $display("%0t: out_x expected %0d actual %0d", $time, e.x, rsp.out_x);
          end
          if (rsp.out_y !== e.y) begin
            errors++;
            $display("%0t: out_y expected %0d actual %0d", $time, e.y, rsp.out_y);
          end
          if (rsp.converged !== e.conv) begin
            errors++;
            $display("%0t: converged expected %0b actual %0b", $time, e.conv,
                     rsp.converged);
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.opcode = OP_REMOVE;
    req.in_x = 0;
    req.in_y = 0;
    rsp.ready = 1'b0;
    for (int i = 0; i < 8; i++) lens_coef[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // zero coefficients: identity map, extremes of the coordinates
    push_point(OP_REMOVE, 0, 0);
    push_point(OP_REMOVE, 32'sh7fffffff, 32'sh80000000);
    push_point(OP_ADD, 32'sh80000000, 32'sh7fffffff);
    push_point(OP_ADD, -1, 1);
    push_point(OP_REMOVE, 32'sh55555555, 32'shaaaaaaaa);
    push_point(OP_ADD, 32'shaaaaaaaa, 32'sh55555555);
    drain();

    load_small_set();
    push_point(OP_REMOVE, 32'sh01000000, 32'sh02000000);
    push_point(OP_ADD, 32'sh01000000, 32'sh02000000);
    push_point(OP_ADD, 0, 0);
    push_random(130, 50);
    drain();

    // coefficient extremes: saturation, and the iteration running out of passes
    for (int i = 0; i < 4; i++) write_coef(REG_COEF_X0 + i, 48'h7fffffffffff);
    for (int i = 0; i < 4; i++) write_coef(REG_COEF_Y0 + i, 48'h800000000000);
    push_point(OP_REMOVE, 0, 0);
    push_point(OP_REMOVE, 32'sh7fffffff, 32'sh7fffffff);
    push_point(OP_REMOVE, 32'sh80000000, 32'sh80000000);
    push_point(OP_REMOVE, 32'sh00100000, -32'sh00100000);
    push_point(OP_ADD, 32'sh00100000, 32'sh00200000);
    push_point(OP_ADD, 32'sh80000000, 32'sh7fffffff);
    drain();

    load_small_set();
    push_random(130, 60);
    drain();

    // constant offsets only, large enough to clamp near the edges
    write_coef(REG_COEF_X0, 48'(rand_mag(46)));
    write_coef(REG_COEF_Y0, 48'(rand_mag(46)));
    for (int i = 1; i < 4; i++) begin
      write_coef(REG_COEF_X0 + i, '0);
      write_coef(REG_COEF_Y0 + i, '0);
    end
    push_random(130, 50);
    drain();

    repeat (200) @(posedge clk);
    $display("covered %0d remove and %0d add transfers, %0d without convergence",
             n_remove, n_add, n_diverged);
    $display("checked %0d results over five coefficient sets", n_checked);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/rlpd_pkg.sv
rtl/rlpd_req_if.sv
rtl/rlpd_rsp_if.sv
rtl/rlpd_mul.sv
rtl/rlpd_sqrt.sv
rtl/rlpd_dp.sv
rtl/rlpd_ctrl.sv
rtl/radial_poly_lens_distortion_map_top.sv
tb/sv/tb_radial_poly_lens_distortion_map_top.sv
